// ===== rtl/krt_pkg.sv =====
// Shared types and codes for the keyed record table.
package krt_pkg;

  localparam int DEPTH_DEF = 64;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_LIST   = 3'd1;
  localparam logic [2:0] OP_SEARCH = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } krt_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_key;
    logic signed [31:0] found_value;
    logic               last;
  } krt_out_t;

  // Source of a result word
  typedef enum logic [1:0] {
    RS_ZERO,
    RS_INPUT,
    RS_RDATA,
    RS_HIT
  } krt_rsel_t;

  typedef struct packed {
    logic       cap_in;
    logic       rd_clr;
    logic       rd_step;
    logic       add_wr;
    logic       upd_wr;
    logic       sh_start;
    logic       sh_step;
    logic       cnt_dec;
    logic       out_load;
    krt_rsel_t  sel;
    logic [1:0] status;
    logic       last;
  } krt_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic miss_end;
    logic sh_done;
    logic list_last;
    logic out_free;
  } krt_sts_t;

endpackage

// ===== rtl/krt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module krt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/krt_datapath.sv =====
// Datapath: record store, count, scan and shift pointers, result register.
module krt_datapath #(
  parameter int DEPTH = krt_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  krt_pkg::krt_cmd_t cmd,
  output krt_pkg::krt_sts_t sts,
  input  krt_pkg::krt_in_t  in_data,
  input  logic              out_ready,
  output logic              out_valid,
  output krt_pkg::krt_out_t out_data
);

  import krt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count_r;
  logic [31:0]        key_r;
  logic [31:0]        value_r;
  logic [CW-1:0]      rd_idx_r;
  logic               cmp_valid_r;
  logic [AW-1:0]      cmp_idx_r;
  logic [AW-1:0]      hit_idx_r;
  logic [31:0]        hit_key_r;
  logic [31:0]        hit_val_r;
  logic [CW-1:0]      dst_r;
  logic               pend_valid_r;
  logic [AW-1:0]      pend_dst_r;
  logic               out_valid_r;
  krt_out_t           out_word_r;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [63:0]        wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [63:0]        rdata;
  logic               rd_issue;
  logic               sh_issue;
  logic [CW-1:0]      src;
  logic               key_eq;
  logic               out_free;
  logic [CW-1:0]      count_m1;

  assign src      = CW'(dst_r + 1'b1);
  assign rd_issue = cmd.rd_step && (rd_idx_r < count_r);
  assign sh_issue = cmd.sh_step && (src < count_r);
  assign key_eq   = (rdata[63:32] == key_r);
  assign out_free = !out_valid_r || out_ready;
  assign count_m1 = CW'(count_r - 1'b1);

  always_comb begin
    we    = 1'b0;
    waddr = count_r[AW-1:0];
    wdata = {key_r, value_r};
    if (cmd.add_wr) begin
      we = 1'b1;
    end else if (cmd.upd_wr) begin
      we    = 1'b1;
      waddr = hit_idx_r;
      wdata = {hit_key_r, value_r};
    end else if (cmd.sh_step && pend_valid_r) begin
      we    = 1'b1;
      waddr = pend_dst_r;
      wdata = rdata;
    end
  end

  always_comb begin
    re    = rd_issue || sh_issue;
    raddr = sh_issue ? src[AW-1:0] : rd_idx_r[AW-1:0];
  end

  krt_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      cmp_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.add_wr) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_m1;
      end
      if (cmd.rd_clr) begin
        cmp_valid_r <= 1'b0;
      end else if (cmd.rd_step) begin
        cmp_valid_r <= rd_issue;
      end
      if (cmd.sh_start) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.sh_step) begin
        pend_valid_r <= sh_issue;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      key_r   <= in_data.key;
      value_r <= in_data.value;
    end
    if (cmd.rd_clr) begin
      rd_idx_r <= '0;
    end else if (rd_issue) begin
      rd_idx_r <= CW'(rd_idx_r + 1'b1);
    end
    if (cmd.rd_step) begin
      cmp_idx_r <= rd_idx_r[AW-1:0];
    end
    // hold the first match; gated so a shift cannot disturb it
    if (cmd.rd_step && cmp_valid_r && key_eq) begin
      hit_idx_r <= cmp_idx_r;
      hit_key_r <= rdata[63:32];
      hit_val_r <= rdata[31:0];
    end else if (cmd.upd_wr) begin
      hit_val_r <= value_r;
    end
    if (cmd.sh_start) begin
      dst_r <= CW'(hit_idx_r);
    end else if (sh_issue) begin
      dst_r <= src;
    end
    if (cmd.sh_step) begin
      pend_dst_r <= dst_r[AW-1:0];
    end
    if (cmd.out_load) begin
      out_word_r.status <= cmd.status;
      out_word_r.last   <= cmd.last;
      case (cmd.sel)
        RS_INPUT: begin
          out_word_r.found_key   <= key_r;
          out_word_r.found_value <= value_r;
        end
        RS_RDATA: begin
          out_word_r.found_key   <= rdata[63:32];
          out_word_r.found_value <= rdata[31:0];
        end
        RS_HIT: begin
          out_word_r.found_key   <= hit_key_r;
          out_word_r.found_value <= hit_val_r;
        end
        default: begin
          out_word_r.found_key   <= '0;
          out_word_r.found_value <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts.full      = (count_r == CW'(DEPTH));
    sts.empty     = (count_r == '0);
    sts.hit       = cmp_valid_r && key_eq;
    sts.miss_end  = cmp_valid_r && !key_eq && (cmp_idx_r == count_m1[AW-1:0]);
    sts.sh_done   = !(src < count_r) && !pend_valid_r;
    sts.list_last = (rd_idx_r == count_r);
    sts.out_free  = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("record count beyond depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result register overwritten before taken");

  a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_wr |-> (count_r != CW'(DEPTH)))
    else $error("append into a full table");

  a_dec_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |=> (count_r == CW'($past(count_r) - 1'b1)))
    else $error("delete did not drop the count by one");

endmodule

// ===== rtl/krt_ctrl.sv =====
// Controller: sequences add, list, scan, update and delete-shift operations.
module krt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_op,
  output logic              in_ready,
  input  krt_pkg::krt_sts_t sts,
  output krt_pkg::krt_cmd_t cmd
);

  import krt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_HIT,
    S_SHIFT,
    S_L_RD,
    S_L_CAP,
    S_RESP
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  krt_rsel_t  rsel_r, rsel_nxt;
  logic [1:0] rstat_r, rstat_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    rsel_nxt  = rsel_r;
    rstat_nxt = rstat_r;
    cmd       = '0;
    cmd.sel   = RS_ZERO;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          op_nxt     = in_op;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_RESP;
        rsel_nxt  = RS_ZERO;
        case (op_r)
          OP_ADD: begin
            if (sts.full) begin
              rstat_nxt = ST_FULL;
            end else begin
              cmd.add_wr = 1'b1;
              rsel_nxt   = RS_INPUT;
              rstat_nxt  = ST_OK;
            end
          end
          OP_LIST: begin
            if (sts.empty) begin
              rstat_nxt = ST_EMPTY;
            end else begin
              cmd.rd_clr = 1'b1;
              state_nxt  = S_L_RD;
            end
          end
          OP_SEARCH, OP_UPDATE, OP_DELETE: begin
            if (sts.empty) begin
              rstat_nxt = ST_NOT_FOUND;
            end else begin
              cmd.rd_clr = 1'b1;
              state_nxt  = S_SCAN;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        cmd.rd_step = 1'b1;
        if (sts.hit) begin
          state_nxt = S_HIT;
        end else if (sts.miss_end) begin
          rsel_nxt  = RS_ZERO;
          rstat_nxt = ST_NOT_FOUND;
          state_nxt = S_RESP;
        end
      end
      S_HIT: begin
        rsel_nxt  = RS_HIT;
        rstat_nxt = ST_OK;
        state_nxt = S_RESP;
        case (op_r)
          OP_UPDATE: cmd.upd_wr = 1'b1;
          OP_DELETE: begin
            cmd.sh_start = 1'b1;
            state_nxt    = S_SHIFT;
          end
          default: ;
        endcase
      end
      S_SHIFT: begin
        // later records move down one place, one per cycle
        cmd.sh_step = 1'b1;
        if (sts.sh_done) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_L_RD: begin
        cmd.rd_step = 1'b1;
        state_nxt   = S_L_CAP;
      end
      S_L_CAP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = RS_RDATA;
          cmd.status   = ST_OK;
          cmd.last     = sts.list_last;
          state_nxt    = sts.list_last ? S_IDLE : S_L_RD;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = rsel_r;
          cmd.status   = rstat_r;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_ADD;
      rsel_r  <= RS_ZERO;
      rstat_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      rsel_r  <= rsel_nxt;
      rstat_r <= rstat_nxt;
    end
  end

endmodule

// ===== rtl/keyed_record_table.sv =====
// Search and update scan one record per cycle until a match or the last record; a delete
// then moves each later record down one place. List alternates a RAM read and a capture
// of the registered read data for each record, waiting while the result register is full.
// One item is in work at a time. Reset clears the record count and the handshakes; RAM
// contents stay undefined, and no clearing pass runs.
module keyed_record_table #(
  parameter int DEPTH = krt_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  krt_pkg::krt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output krt_pkg::krt_out_t out_data
);

  import krt_pkg::*;

  krt_cmd_t cmd;
  krt_sts_t sts;

  krt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_op   (in_data.op),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  krt_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for keyed_record_table: table predictor, scoreboard and drivers.
module tb_top;
  import krt_pkg::*;

  localparam int TBL_DEPTH   = DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam int REPORT_MAX  = 10;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  krt_in_t  in_data;
  logic     out_valid;
  logic     out_ready = 1'b0;
  krt_out_t out_data;

  int send_idle;
  int recv_idle;
  int quiet_cycles;
  bit filling;

  logic signed [31:0] key_pool [8] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000,
                                       32'shffff_ffff, 32'sh0000_0001, 32'sh0000_002a,
                                       32'sh5555_5555, 32'shaaaa_aaaa};

  // Predicts the table and holds the words still owed by the block
  class record_table_check;
    logic signed [31:0] key_tab [TBL_DEPTH];
    logic signed [31:0] val_tab [TBL_DEPTH];
    int unsigned count;
    krt_out_t due_words[$];
    int errors;
    int n_requests, n_words, n_list_words, n_full, n_empty, n_miss, n_hit, peak_count;

    function void owe(logic [1:0] st, logic signed [31:0] k, logic signed [31:0] v, logic l);
      krt_out_t w;
      w.status      = st;
      w.found_key   = k;
      w.found_value = v;
      w.last        = l;
      due_words.push_back(w);
    endfunction

    function void take_request(krt_in_t w);
      int hit_at;
      hit_at = -1;
      n_requests++;
      case (w.op)
        OP_ADD: begin
          if (count >= TBL_DEPTH) begin
            owe(ST_FULL, '0, '0, 1'b1);
            n_full++;
          end else begin
            key_tab[count] = w.key;
            val_tab[count] = w.value;
            count++;
            if (count > peak_count) peak_count = count;
            owe(ST_OK, w.key, w.value, 1'b1);
          end
        end
        OP_LIST: begin
          if (count == 0) begin
            owe(ST_EMPTY, '0, '0, 1'b1);
            n_empty++;
          end else begin
            for (int i = 0; i < count; i++)
              owe(ST_OK, key_tab[i], val_tab[i], (i == count - 1));
            n_list_words += count;
          end
        end
        OP_SEARCH, OP_UPDATE, OP_DELETE: begin
          for (int i = 0; i < count; i++)
            if (hit_at < 0 && key_tab[i] == w.key) hit_at = i;
          if (hit_at < 0) begin
            owe(ST_NOT_FOUND, '0, '0, 1'b1);
            n_miss++;
          end else begin
            n_hit++;
            if (w.op == OP_UPDATE) val_tab[hit_at] = w.value;
            owe(ST_OK, key_tab[hit_at], val_tab[hit_at], 1'b1);
            if (w.op == OP_DELETE) begin
              for (int j = hit_at; j + 1 < count; j++) begin
                key_tab[j] = key_tab[j + 1];
                val_tab[j] = val_tab[j + 1];
              end
              count--;
            end
          end
        end
        default: ;  // spare op codes: no word, no change
      endcase
    endfunction

    function void check_word(krt_out_t got);
      krt_out_t want;
      n_words++;
      if (due_words.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("[%0t] unexpected word: st=%0d key=%0d val=%0d last=%0b",
                   $realtime, got.status, got.found_key, got.found_value, got.last);
        return;
      end
      want = due_words.pop_front();
      if (got.status !== want.status || got.found_key !== want.found_key ||
          got.found_value !== want.found_value || got.last !== want.last) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("[%0t] mismatch: exp st=%0d key=%0d val=%0d last=%0b, got st=%0d key=%0d val=%0d last=%0b",
                   $realtime, want.status, want.found_key, want.found_value, want.last,
                   got.status, got.found_key, got.found_value, got.last);
      end
    endfunction

    function void close_out();
      if (due_words.size() != 0) begin
        errors++;
        $display("%0d expected words never arrived", due_words.size());
      end
    endfunction
  endclass

  record_table_check tbl = new;

  keyed_record_table #(.DEPTH(TBL_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tbl.check_word(out_data);
  end

  // Watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Entered and left at a falling edge; valid stays up after acceptance until the caller moves on
  task automatic send_word(input krt_in_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tbl.take_request(w);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [2:0] op, input logic signed [31:0] k,
                         input logic signed [31:0] v);
    krt_in_t w;
    w.op    = op;
    w.key   = k;
    w.value = v;
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (tbl.due_words.size() != 0);
  endtask

  task automatic run_random(input int n_items);
    int done_items;
    int r;
    krt_in_t w;
    done_items = 0;
    while (done_items < n_items) begin
      r = $urandom_range(99);
      if (filling) begin
        if (r < 72)      w.op = OP_ADD;
        else if (r < 76) w.op = OP_LIST;
        else if (r < 84) w.op = OP_SEARCH;
        else if (r < 91) w.op = OP_UPDATE;
        else if (r < 97) w.op = OP_DELETE;
        else             w.op = OP_DELETE + 3'($urandom_range(3, 1));
      end else begin
        if (r < 15)      w.op = OP_ADD;
        else if (r < 19) w.op = OP_LIST;
        else if (r < 31) w.op = OP_SEARCH;
        else if (r < 41) w.op = OP_UPDATE;
        else if (r < 95) w.op = OP_DELETE;
        else             w.op = OP_DELETE + 3'($urandom_range(3, 1));
      end
      // lookups mostly aim at stored keys so hits, duplicates and shifts happen
      if (w.op != OP_ADD && tbl.count > 0 && $urandom_range(9) < 7)
        w.key = tbl.key_tab[$urandom_range(tbl.count - 1)];
      else if ($urandom_range(9) < 4)
        w.key = key_pool[$urandom_range(7)];
      else
        w.key = $urandom;
      w.value = $urandom;
      send_word(w);
      if (w.op <= OP_DELETE) done_items++;
      if (filling && tbl.count == TBL_DEPTH && $urandom_range(4) == 0) filling = 1'b0;
      else if (!filling && tbl.count == 0) filling = 1'b1;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    quiet_cycles = 0;
    send_idle    = 21;
    recv_idle    = 71;
    filling      = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table
    send_op(OP_LIST,   32'sd0, 32'sd0);
    send_op(OP_SEARCH, 32'sd5, 32'sd0);
    send_op(OP_UPDATE, 32'sd5, 32'sd9);
    send_op(OP_DELETE, 32'sd5, 32'sd0);
    // extremes and a duplicate key
    send_op(OP_ADD, 32'sh8000_0000, 32'sh7fff_ffff);
    send_op(OP_ADD, 32'sh7fff_ffff, 32'sh8000_0000);
    send_op(OP_ADD, 32'sd0, 32'sd0);
    send_op(OP_ADD, -32'sd1, -32'sd1);
    send_op(OP_ADD, 32'sh0000_1234, 32'sd1);
    send_op(OP_ADD, 32'sh7fff_ffff, 32'sd7);
    send_op(OP_SEARCH, 32'sh7fff_ffff, 32'sd0);
    send_op(OP_UPDATE, 32'sh7fff_ffff, -32'sd5);
    send_op(OP_SEARCH, 32'sd99, 32'sd0);
    send_op(OP_LIST,   32'sd0, 32'sd0);
    send_op(OP_DELETE, 32'sh7fff_ffff, 32'sd0);
    send_op(OP_SEARCH, 32'sh7fff_ffff, 32'sd0);
    // the second duplicate now sits in the final slot
    send_op(OP_DELETE, 32'sh7fff_ffff, 32'sd0);
    send_op(OP_DELETE, 32'sd7777, 32'sd0);
    for (int n = 1; n <= 3; n++)
      send_op(OP_DELETE + 3'(n), $urandom, $urandom);
    send_op(OP_LIST,   32'sd0, 32'sd0);
    send_op(OP_DELETE, 32'sh8000_0000, 32'sd0);
    send_op(OP_LIST,   32'sd0, 32'sd0);
    wait_drained();

    run_random(100);
    wait_drained();
    send_idle = 71;
    recv_idle = 21;
    run_random(100);
    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    run_random(100);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    tbl.close_out();
    $display("Sent %0d requests, checked %0d words: %0d list words, %0d hits, %0d misses,",
             tbl.n_requests, tbl.n_words, tbl.n_list_words, tbl.n_hit, tbl.n_miss);
    $display("%0d full refusals, %0d empty lists, peak fill %0d of %0d; %0d failures",
             tbl.n_full, tbl.n_empty, tbl.peak_count, TBL_DEPTH, tbl.errors);
    if (tbl.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
